>>> src/thc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Thermostat controller package
// Shared widths, register indexes, reset defaults and operating state codes.
// ----------------------------------------------------------------------------
package thc_pkg;

    localparam int NOW_W   = 32;
    localparam int DELAY_W = 16;
    localparam int PRESS_W = 8;
    localparam int SP_W    = 7;
    localparam int BAND_W  = 4;
    localparam int TEMP_W  = 8;
    localparam int SUM_W   = 14;
    localparam int SEC_W   = 6;
    localparam int OP_W    = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Averaging window length in valid seconds (1..63)
    localparam int WINDOW_SECONDS = 60;

    // Reciprocal for sum / WINDOW_SECONDS, rounded up; exact for |sum| <= 128*window
    localparam int RECIP_SHIFT = 20;
    localparam int RECIP       = ((1 << RECIP_SHIFT) + WINDOW_SECONDS - 1) / WINDOW_SECONDS;
    localparam int RECIP_W     = $clog2(RECIP + 1);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BOUNCE_DELAY  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PRESSES   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SETPOINT_MIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SETPOINT_MAX  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_STEP     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_SETPOINT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_START_AVERAGE = 3'd6;

    // Reset defaults
    localparam logic [DELAY_W-1:0]       RST_BOUNCE_DELAY  = 16'd20;
    localparam logic [PRESS_W-1:0]       RST_MIN_PRESSES   = 8'd3;
    localparam logic [SP_W-1:0]          RST_SETPOINT_MIN  = 7'd5;
    localparam logic [SP_W-1:0]          RST_SETPOINT_MAX  = 7'd30;
    localparam logic [BAND_W-1:0]        RST_BAND_STEP     = 4'd1;
    localparam logic [SP_W-1:0]          RST_INIT_SETPOINT = 7'd24;
    localparam logic signed [TEMP_W-1:0] RST_START_AVERAGE = 8'sd24;

    // Operating state codes
    localparam logic [OP_W-1:0] OP_STOP = 2'd0;
    localparam logic [OP_W-1:0] OP_HEAT = 2'd1;
    localparam logic [OP_W-1:0] OP_COOL = 2'd2;

    typedef struct packed {
        logic [DELAY_W-1:0] bounce_delay;
        logic [PRESS_W-1:0] min_presses;
    } button_cfg_t;

endpackage : thc_pkg
`default_nettype wire

>>> src/thermostat_hysteresis_controller_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Thermostat hysteresis controller
// Bang-bang heat/cool control with button setpoint entry and a windowed
// temperature average.
// ----------------------------------------------------------------------------
// Each input transfer is one control pass and yields exactly one result
// transfer. The block is a two-register pipeline: the input register holds the
// pass, and combinational logic (button debounce, setpoint step, mode and stop
// hysteresis, averaging with a reciprocal multiply) loads the result register
// and the controller state together once the result register is free or
// draining. A new pass is taken every cycle as long as the
// result side keeps up; with the result register full and stalled, one more
// pass waits in the input register. Control uses the average as it stood
// before the pass; the reported average is the one after it. Registers 5
// (initial setpoint) and 6 (start average) only matter at reset, which restores
// their default values, so writes to them have no effect on the running state.
// Configure only while no pass is in flight.
// ----------------------------------------------------------------------------
module thermostat_hysteresis_controller_top (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    // configuration
    input  wire logic                                  cfg_wr_en,
    input  wire logic [thc_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [thc_pkg::CFG_DATA_W-1:0]        cfg_wdata,
    // input channel
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic [thc_pkg::NOW_W-1:0]             s_now_ms,
    input  wire logic                                  s_down_level,
    input  wire logic                                  s_up_level,
    input  wire logic                                  s_second_tick,
    input  wire logic signed [thc_pkg::TEMP_W-1:0]     s_temp_sample,
    input  wire logic                                  s_sample_valid,
    // result channel
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic [thc_pkg::SP_W-1:0]                   m_setpoint,
    output logic signed [thc_pkg::TEMP_W-1:0]          m_average_temp,
    output logic                                       m_heating,
    output logic                                       m_stopped,
    output logic [thc_pkg::OP_W-1:0]                   m_op_state,
    output logic                                       m_heat_relay_n,
    output logic                                       m_cool_relay_n
);
    import thc_pkg::*;

    localparam int CTL_W  = 10;
    localparam int PROD_W = SUM_W + RECIP_W;

    // ---------------- configuration registers ----------------
    logic [DELAY_W-1:0] bounce_delay_reg;
    logic [PRESS_W-1:0] min_presses_reg;
    logic [SP_W-1:0]    setpoint_min_reg;
    logic [SP_W-1:0]    setpoint_max_reg;
    logic [BAND_W-1:0]  band_step_reg;
    button_cfg_t        btn_cfg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bounce_delay_reg <= RST_BOUNCE_DELAY;
            min_presses_reg  <= RST_MIN_PRESSES;
            setpoint_min_reg <= RST_SETPOINT_MIN;
            setpoint_max_reg <= RST_SETPOINT_MAX;
            band_step_reg    <= RST_BAND_STEP;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_BOUNCE_DELAY: begin
                    bounce_delay_reg <= cfg_wdata;
                end
                CFG_MIN_PRESSES: begin
                    min_presses_reg <= cfg_wdata[PRESS_W-1:0];
                end
                CFG_SETPOINT_MIN: begin
                    setpoint_min_reg <= cfg_wdata[SP_W-1:0];
                end
                CFG_SETPOINT_MAX: begin
                    setpoint_max_reg <= cfg_wdata[SP_W-1:0];
                end
                CFG_BAND_STEP: begin
                    band_step_reg <= cfg_wdata[BAND_W-1:0];
                end
                // reset-only registers and unused indexes: drop the write
                default: begin
                end
            endcase
        end
    end

    assign btn_cfg.bounce_delay = bounce_delay_reg;
    assign btn_cfg.min_presses  = min_presses_reg;

    // ---------------- pipeline handshake ----------------
    logic in_vld_reg;
    logic out_vld_reg;
    logic advance;
    logic in_take;

    // move the held pass into the result register when that is free or draining
    assign advance = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || advance;
    assign in_take = s_valid && s_ready;
    assign m_valid = out_vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (in_take) begin
                in_vld_reg <= 1'b1;
            end else if (advance) begin
                in_vld_reg <= 1'b0;
            end
            if (advance) begin
                out_vld_reg <= 1'b1;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // ---------------- input register ----------------
    logic [NOW_W-1:0]          now_reg;
    logic                      down_reg;
    logic                      up_reg;
    logic                      tick_reg;
    logic signed [TEMP_W-1:0]  sample_reg;
    logic                      sample_ok_reg;

    always_ff @(posedge aclk) begin
        if (in_take) begin
            now_reg       <= s_now_ms;
            down_reg      <= s_down_level;
            up_reg        <= s_up_level;
            tick_reg      <= s_second_tick;
            sample_reg    <= s_temp_sample;
            sample_ok_reg <= s_sample_valid;
        end
    end

    // ---------------- buttons and setpoint ----------------
    logic            down_step;
    logic            up_step;
    logic [SP_W-1:0] user_sp_reg, user_sp_next;
    logic [SP_W-1:0] sp_after_down;

    thc_button u_btn_down (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .now_ms  (now_reg),
        .level   (down_reg),
        .cfg     (btn_cfg),
        .step    (down_step)
    );

    thc_button u_btn_up (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .now_ms  (now_reg),
        .level   (up_reg),
        .cfg     (btn_cfg),
        .step    (up_step)
    );

    // down is handled before up within one pass
    always_comb begin
        sp_after_down = user_sp_reg;
        if (down_step && (user_sp_reg > setpoint_min_reg)) begin
            sp_after_down = user_sp_reg - SP_W'(1);
        end
        user_sp_next = sp_after_down;
        if (up_step && (sp_after_down < setpoint_max_reg)) begin
            user_sp_next = sp_after_down + SP_W'(1);
        end
    end

    // ---------------- mode and stop hysteresis ----------------
    logic                     heat_mode_reg, heat_mode_next;
    logic                     stop_reg, stop_next;
    logic signed [TEMP_W-1:0] avg_reg, avg_next;
    logic signed [CTL_W-1:0]  t_ext;
    logic signed [CTL_W-1:0]  sp_ext;
    logic signed [CTL_W-1:0]  band_ext;
    logic signed [CTL_W-1:0]  sp_hi2, sp_lo2, sp_hi1, sp_lo1;
    logic                     mode_flip;
    logic [OP_W-1:0]          op_next;

    assign t_ext    = CTL_W'(avg_reg);
    assign sp_ext   = signed'({{(CTL_W-SP_W){1'b0}}, user_sp_next});
    assign band_ext = signed'({{(CTL_W-BAND_W){1'b0}}, band_step_reg});
    assign sp_hi1   = sp_ext + band_ext;
    assign sp_lo1   = sp_ext - band_ext;
    assign sp_hi2   = sp_hi1 + band_ext;
    assign sp_lo2   = sp_lo1 - band_ext;

    assign mode_flip      = heat_mode_reg ? (t_ext > sp_hi2) : (t_ext < sp_lo2);
    assign heat_mode_next = heat_mode_reg ^ mode_flip;

    always_comb begin
        if (!stop_reg) begin
            if (heat_mode_next) begin
                stop_next = (t_ext > sp_ext) && (t_ext >= sp_hi1);
            end else begin
                stop_next = (t_ext < sp_ext) && (t_ext <= sp_lo1);
            end
        end else begin
            stop_next = heat_mode_next ? (t_ext >= sp_ext) : (t_ext <= sp_ext);
        end
    end

    assign op_next = stop_next ? OP_STOP : (heat_mode_next ? OP_HEAT : OP_COOL);

    // ---------------- averaging ----------------
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic signed [SUM_W-1:0] sum_acc;
    logic [SEC_W-1:0]        secs_reg, secs_next;
    logic [SEC_W-1:0]        secs_inc;
    logic                    sum_neg;
    logic [SUM_W-1:0]        sum_mag;
    logic [PROD_W-1:0]       quot_prod;
    logic [TEMP_W-1:0]       quot_mag;
    logic signed [TEMP_W-1:0] quot;

    assign sum_acc  = sum_reg + SUM_W'(sample_reg);
    assign secs_inc = secs_reg + SEC_W'(1);

    // truncating divide by the window: divide the magnitude, restore the sign
    assign sum_neg   = sum_acc[SUM_W-1];
    assign sum_mag   = sum_neg ? SUM_W'(-sum_acc) : SUM_W'(sum_acc);
    assign quot_prod = PROD_W'(sum_mag) * PROD_W'(RECIP);
    assign quot_mag  = quot_prod[RECIP_SHIFT +: TEMP_W];
    assign quot      = sum_neg ? signed'(TEMP_W'(-quot_mag)) : signed'(quot_mag);

    always_comb begin
        avg_next  = avg_reg;
        sum_next  = sum_reg;
        secs_next = secs_reg;
        if (tick_reg && sample_ok_reg) begin
            if (secs_inc >= SEC_W'(WINDOW_SECONDS)) begin
                avg_next  = quot;
                sum_next  = '0;
                secs_next = '0;
            end else begin
                sum_next  = sum_acc;
                secs_next = secs_inc;
            end
        end
    end

    // ---------------- controller state ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            user_sp_reg   <= RST_INIT_SETPOINT;
            heat_mode_reg <= 1'b1;
            stop_reg      <= 1'b1;
            avg_reg       <= RST_START_AVERAGE;
            sum_reg       <= '0;
            secs_reg      <= '0;
        end else if (advance) begin
            user_sp_reg   <= user_sp_next;
            heat_mode_reg <= heat_mode_next;
            stop_reg      <= stop_next;
            avg_reg       <= avg_next;
            sum_reg       <= sum_next;
            secs_reg      <= secs_next;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge aclk) begin
        if (advance) begin
            m_setpoint     <= user_sp_next;
            m_average_temp <= avg_next;
            m_heating      <= heat_mode_next;
            m_stopped      <= stop_next;
            m_op_state     <= op_next;
            m_heat_relay_n <= (op_next != OP_HEAT);
            m_cool_relay_n <= (op_next != OP_COOL);
        end
    end

`ifndef SYNTHESIS
    // a stalled input side means both registers hold a pass
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_vld_reg && out_vld_reg))
        else $error("input stalled with a free pipeline register");

    // the window counter never reaches the window length
    assert property (@(posedge aclk) disable iff (!aresetn)
        secs_reg < SEC_W'(WINDOW_SECONDS))
        else $error("valid second count escaped the window");

    // the heat relay agrees with the reported state and the relays never both drive
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_stopped == (m_op_state == OP_STOP))
                     && (m_heat_relay_n || m_cool_relay_n)
                     && (m_heat_relay_n == (m_op_state != OP_HEAT))))
        else $error("relay drive inconsistent with operating state");

    // a completed pass leaves a result behind
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_vld_reg)
        else $error("pass advanced without a result");
`endif

endmodule : thermostat_hysteresis_controller_top
`default_nettype wire

>>> src/thc_button.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Button press counter
// Debounce one active-low button by time stamp and flag a setpoint step.
// ----------------------------------------------------------------------------
module thc_button (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     advance,
    input  wire logic [thc_pkg::NOW_W-1:0] now_ms,
    input  wire logic                     level,
    input  wire thc_pkg::button_cfg_t     cfg,
    output logic                          step
);
    import thc_pkg::*;

    logic [NOW_W-1:0]   stamp_reg, stamp_next;
    logic [PRESS_W-1:0] count_reg, count_next;
    logic [NOW_W-1:0]   elapsed;
    logic               interval_done;
    logic [PRESS_W-1:0] count_inc;

    assign elapsed       = now_ms - stamp_reg;
    assign interval_done = elapsed > {{(NOW_W-DELAY_W){1'b0}}, cfg.bounce_delay};
    assign count_inc     = count_reg + PRESS_W'(1);

    always_comb begin
        stamp_next = stamp_reg;
        count_next = count_reg;
        step       = 1'b0;
        if (level) begin
            stamp_next = now_ms;
            count_next = '0;
        end else if (interval_done) begin
            stamp_next = now_ms;
            count_next = count_inc;
            step       = (count_inc == cfg.min_presses);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stamp_reg <= '0;
            count_reg <= '0;
        end else if (advance) begin
            stamp_reg <= stamp_next;
            count_reg <= count_next;
        end
    end

endmodule : thc_button
`default_nettype wire

>>> verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thermostat hysteresis controller testbench
// Drives control passes through the valid/ready input channel, predicts each
// status transfer with an in-bench model of the controller and compares
// every returned status field by field. A short table of directed passes runs
// first, followed by random button, tick and temperature traffic under several
// register settings, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb;
    import thc_pkg::*;

    // Button slots in the press trackers
    localparam int BTN_DOWN = 0;
    localparam int BTN_UP   = 1;

    localparam int IDLE_PCT    = 30;  // chance of an idle cycle on either side
    localparam int HOLD_CYCLES = 40;  // length of the long result-side hold-off
    localparam int DRAIN_WAIT  = 8;   // cycles allowed after the last status
    localparam int MAX_REPORTS = 10;

    // One control pass as offered on the input channel
    typedef struct packed {
        logic [NOW_W-1:0]         now_ms;
        logic                     down_level;
        logic                     up_level;
        logic                     second_tick;
        logic signed [TEMP_W-1:0] temp_sample;
        logic                     sample_valid;
    } pass_t;

    // Controller status returned for one pass
    typedef struct packed {
        logic [SP_W-1:0]          setpoint;
        logic signed [TEMP_W-1:0] average_temp;
        logic                     heating;
        logic                     stopped;
        logic [OP_W-1:0]          op_state;
        logic                     heat_relay_n;
        logic                     cool_relay_n;
    } status_t;

    // Directed row: the pass, and a typed-in status where it is obvious
    typedef struct packed {
        pass_t   stim;
        logic    typed;
        status_t want;
    } stim_row_t;

    localparam status_t IDLE_AT_RESET = '{7'd24, 8'sd24, 1'b1, 1'b1, OP_STOP, 1'b1, 1'b1};
    localparam status_t NO_STATUS     = '0;

    // Defaults in force: delay 20 ms, 3 presses, limits 5..30, band 1.
    localparam int N_OPENING = 17;
    localparam stim_row_t OPENING_PASSES [N_OPENING] = '{
        // released buttons, no tick: state straight out of reset
        '{'{32'd0,            1'b1, 1'b1, 1'b0,  8'sd0,  1'b0}, 1'b1, IDLE_AT_RESET},
        // coldest and hottest valid samples, time stamp at its top value
        '{'{32'hFFFF_FFFF,    1'b1, 1'b1, 1'b1, -8'sd40, 1'b1}, 1'b1, IDLE_AT_RESET},
        '{'{32'd100,          1'b1, 1'b1, 1'b1,  8'sd80, 1'b1}, 1'b1, IDLE_AT_RESET},
        // tick with an invalid sample is dropped
        '{'{32'd150,          1'b1, 1'b1, 1'b1, -8'sd1,  1'b0}, 1'b1, IDLE_AT_RESET},
        // hold down: 21 ms counts, exactly 20 ms does not
        '{'{32'd171,          1'b0, 1'b1, 1'b0,  8'sd0,  1'b0}, 1'b0, NO_STATUS},
        '{'{32'd191,          1'b0, 1'b1, 1'b0,  8'sd0,  1'b0}, 1'b0, NO_STATUS},
        '{'{32'd192,          1'b0, 1'b1, 1'b0,  8'sd0,  1'b0}, 1'b0, NO_STATUS},
        '{'{32'd213,          1'b0, 1'b1, 1'b0,  8'sd0,  1'b0}, 1'b0, NO_STATUS},
        '{'{32'd234,          1'b0, 1'b1, 1'b0,  8'sd0,  1'b0}, 1'b0, NO_STATUS},
        // both buttons held: down is handled ahead of up
        '{'{32'd255,          1'b0, 1'b0, 1'b0,  8'sd0,  1'b0}, 1'b0, NO_STATUS},
        '{'{32'd276,          1'b0, 1'b0, 1'b0,  8'sd0,  1'b0}, 1'b0, NO_STATUS},
        '{'{32'd297,          1'b0, 1'b0, 1'b1,  8'sd0,  1'b1}, 1'b0, NO_STATUS},
        // huge gap, then time stamps that wrap around
        '{'{32'h8000_0000,    1'b0, 1'b1, 1'b1,  8'sd0,  1'b1}, 1'b0, NO_STATUS},
        '{'{32'h8000_0000,    1'b1, 1'b1, 1'b0,  8'sd0,  1'b0}, 1'b0, NO_STATUS},
        '{'{32'h7FFF_FFF0,    1'b1, 1'b0, 1'b1,  8'sd79, 1'b1}, 1'b0, NO_STATUS},
        '{'{32'h0000_0005,    1'b1, 1'b0, 1'b1, -8'sd39, 1'b1}, 1'b0, NO_STATUS},
        '{'{32'h0000_0005,    1'b1, 1'b0, 1'b1,  8'sd1,  1'b0}, 1'b0, NO_STATUS}
    };

    // ------------------------------------------------------------------------
    // Block under test
    // ------------------------------------------------------------------------
    logic                     aclk;
    logic                     aresetn;
    logic                     cfg_wr_en;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [CFG_DATA_W-1:0]    cfg_wdata;
    logic                     s_valid;
    logic                     s_ready;
    logic [NOW_W-1:0]         s_now_ms;
    logic                     s_down_level;
    logic                     s_up_level;
    logic                     s_second_tick;
    logic signed [TEMP_W-1:0] s_temp_sample;
    logic                     s_sample_valid;
    logic                     m_valid;
    logic                     m_ready;
    logic [SP_W-1:0]          m_setpoint;
    logic signed [TEMP_W-1:0] m_average_temp;
    logic                     m_heating;
    logic                     m_stopped;
    logic [OP_W-1:0]          m_op_state;
    logic                     m_heat_relay_n;
    logic                     m_cool_relay_n;

    thermostat_hysteresis_controller_top u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_now_ms       (s_now_ms),
        .s_down_level   (s_down_level),
        .s_up_level     (s_up_level),
        .s_second_tick  (s_second_tick),
        .s_temp_sample  (s_temp_sample),
        .s_sample_valid (s_sample_valid),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_setpoint     (m_setpoint),
        .m_average_temp (m_average_temp),
        .m_heating      (m_heating),
        .m_stopped      (m_stopped),
        .m_op_state     (m_op_state),
        .m_heat_relay_n (m_heat_relay_n),
        .m_cool_relay_n (m_cool_relay_n)
    );

    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Controller model: register copies and running state
    // ------------------------------------------------------------------------
    logic [DELAY_W-1:0]       reg_delay;
    logic [PRESS_W-1:0]       reg_presses;
    logic [SP_W-1:0]          reg_sp_min;
    logic [SP_W-1:0]          reg_sp_max;
    logic [BAND_W-1:0]        reg_band;
    logic [SP_W-1:0]          reg_init_sp;    // written but never read
    logic signed [TEMP_W-1:0] reg_start_avg;  // written but never read

    logic [NOW_W-1:0]   btn_stamp [2];
    logic [PRESS_W-1:0] btn_count [2];
    logic [SP_W-1:0]    cur_setpoint;
    logic               mode_heat;
    logic               idle_flag;
    int                 avg_now;
    int                 sec_sum;
    int                 sec_count;

    status_t due_status [$];   // statuses still owed by the block

    // Run bookkeeping
    int  passes_sent;
    int  status_seen;
    int  status_bad;
    int  windows_done;
    int  setpoint_steps;
    int  settings_used;
    bit  steady;               // no idling on either side
    bit  hold_req;             // ask the result side for a long hold-off

    // Random traffic shaping
    logic [NOW_W-1:0] sim_ms;
    bit               held [2];
    int               temp_target;

    // One debounce interval for one button; a completed run of intervals
    // steps the setpoint within its limits.
    task automatic track_button(input int b, input logic level, input logic [NOW_W-1:0] now);
        logic [NOW_W-1:0] elapsed;
        elapsed = now - btn_stamp[b];
        if (level) begin
            btn_stamp[b] = now;
            btn_count[b] = '0;
        end else if (elapsed > NOW_W'(reg_delay)) begin
            btn_stamp[b] = now;
            btn_count[b] = btn_count[b] + PRESS_W'(1);
            if (btn_count[b] == reg_presses) begin
                if (b == BTN_UP && cur_setpoint < reg_sp_max) begin
                    cur_setpoint = cur_setpoint + SP_W'(1);
                    setpoint_steps++;
                end
                if (b == BTN_DOWN && cur_setpoint > reg_sp_min) begin
                    cur_setpoint = cur_setpoint - SP_W'(1);
                    setpoint_steps++;
                end
            end
        end
    endtask

    // Full control pass: buttons, mode and stop hysteresis, then averaging
    task automatic control_pass(input pass_t p, output status_t r);
        int sp;
        int band;
        int t;
        logic [OP_W-1:0] op;
        track_button(BTN_DOWN, p.down_level, p.now_ms);
        track_button(BTN_UP, p.up_level, p.now_ms);
        sp   = int'(cur_setpoint);
        band = int'(reg_band);
        t    = avg_now;

        if (mode_heat ? (t > sp + 2 * band) : (t < sp - 2 * band))
            mode_heat = !mode_heat;

        if (!idle_flag) begin
            if (mode_heat)
                idle_flag = (t > sp) && (t >= sp + band);
            else
                idle_flag = (t < sp) && (t <= sp - band);
        end else begin
            idle_flag = mode_heat ? (t >= sp) : (t <= sp);
        end

        op = idle_flag ? OP_STOP : (mode_heat ? OP_HEAT : OP_COOL);

        if (p.second_tick && p.sample_valid) begin
            sec_sum += int'($signed(p.temp_sample));
            sec_count++;
            if (sec_count >= WINDOW_SECONDS) begin
                avg_now   = sec_sum / WINDOW_SECONDS;
                sec_sum   = 0;
                sec_count = 0;
                windows_done++;
            end
        end

        r.setpoint     = cur_setpoint;
        r.average_temp = avg_now[TEMP_W-1:0];
        r.heating      = mode_heat;
        r.stopped      = idle_flag;
        r.op_state     = op;
        r.heat_relay_n = (op != OP_HEAT);
        r.cool_relay_n = (op != OP_COOL);
    endtask

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------
    // Offer one pass and hold it until the transfer; predict on acceptance.
    // The typed-in status, where given, stands in for the predicted one.
    task automatic offer_pass(input pass_t p, input logic typed, input status_t want);
        status_t r;
        if (!steady && !hold_req && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < IDLE_PCT);
        end
        s_valid        <= 1'b1;
        s_now_ms       <= p.now_ms;
        s_down_level   <= p.down_level;
        s_up_level     <= p.up_level;
        s_second_tick  <= p.second_tick;
        s_temp_sample  <= p.temp_sample;
        s_sample_valid <= p.sample_valid;
        do @(posedge aclk); while (!s_ready);
        control_pass(p, r);
        due_status.push_back(typed ? want : r);
        passes_sent++;
    endtask

    // Drop valid and wait until every owed status has come back
    task automatic drain_status();
        s_valid <= 1'b0;
        while (due_status.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
    endtask

    // Reprogram every register with the block idle
    task automatic program_settings(input logic [DELAY_W-1:0] delay,
                                    input logic [PRESS_W-1:0] presses,
                                    input logic [SP_W-1:0] sp_lo,
                                    input logic [SP_W-1:0] sp_hi,
                                    input logic [BAND_W-1:0] band,
                                    input logic [SP_W-1:0] init_sp,
                                    input logic signed [TEMP_W-1:0] start_avg);
        drain_status();
        // let the last pass settle in the pipeline
        repeat (4) @(posedge aclk);
        write_reg(CFG_BOUNCE_DELAY, CFG_DATA_W'(delay));
        write_reg(CFG_MIN_PRESSES, CFG_DATA_W'(presses));
        write_reg(CFG_SETPOINT_MIN, CFG_DATA_W'(sp_lo));
        write_reg(CFG_SETPOINT_MAX, CFG_DATA_W'(sp_hi));
        write_reg(CFG_BAND_STEP, CFG_DATA_W'(band));
        write_reg(CFG_INIT_SETPOINT, CFG_DATA_W'(init_sp));
        write_reg(CFG_START_AVERAGE, {{(CFG_DATA_W - TEMP_W){start_avg[TEMP_W-1]}}, start_avg});
        cfg_wr_en     <= 1'b0;
        reg_delay     = delay;
        reg_presses   = presses;
        reg_sp_min    = sp_lo;
        reg_sp_max    = sp_hi;
        reg_band      = band;
        reg_init_sp   = init_sp;
        reg_start_avg = start_avg;
        settings_used++;
    endtask

    // Pick a temperature level to sit at for a while; mostly around the
    // setpoint so that the average crosses the hysteresis bands.
    task automatic pick_target();
        int band;
        band = int'(reg_band);
        if ($urandom_range(0, 3) != 0)
            temp_target = int'(cur_setpoint) + int'($urandom_range(0, 4 * band + 6))
                          - (2 * band + 3);
        else
            temp_target = int'($urandom_range(0, 120)) - 40;
    endtask

    // Random passes: buttons held for stretches with the odd glitch, time
    // advancing around the debounce delay, samples scattered about a target.
    task automatic run_random(input int count);
        pass_t p;
        int    v;
        logic  lvl [2];
        for (int i = 0; i < count; i++) begin
            for (int b = 0; b < 2; b++) begin
                if ($urandom_range(0, 9) == 0)
                    held[b] = !held[b];
                lvl[b] = !held[b];
                if ($urandom_range(0, 19) == 0)
                    lvl[b] = !lvl[b];
            end
            if ($urandom_range(0, 39) == 0)
                sim_ms = $urandom();
            else
                sim_ms = sim_ms + NOW_W'($urandom_range(0, 2 * int'(reg_delay) + 2));
            if ($urandom_range(0, 63) == 0)
                pick_target();
            v = temp_target + int'($urandom_range(0, 6)) - 3;
            if ($urandom_range(0, 15) == 0)
                v = $urandom_range(0, 1) ? 80 : -40;
            if (v > 80)
                v = 80;
            if (v < -40)
                v = -40;
            p.now_ms       = sim_ms;
            p.down_level   = lvl[BTN_DOWN];
            p.up_level     = lvl[BTN_UP];
            p.second_tick  = 1'($urandom_range(0, 1));
            p.sample_valid = ($urandom_range(0, 7) != 0);
            p.temp_sample  = v[TEMP_W-1:0];
            offer_pass(p, 1'b0, NO_STATUS);
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        // every input known from time zero
        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_index      = '0;
        cfg_wdata      = '0;
        s_valid        = 1'b0;
        s_now_ms       = '0;
        s_down_level   = 1'b1;
        s_up_level     = 1'b1;
        s_second_tick  = 1'b0;
        s_temp_sample  = '0;
        s_sample_valid = 1'b0;

        // model state as it stands after reset
        reg_delay     = RST_BOUNCE_DELAY;
        reg_presses   = RST_MIN_PRESSES;
        reg_sp_min    = RST_SETPOINT_MIN;
        reg_sp_max    = RST_SETPOINT_MAX;
        reg_band      = RST_BAND_STEP;
        reg_init_sp   = RST_INIT_SETPOINT;
        reg_start_avg = RST_START_AVERAGE;
        btn_stamp     = '{default: '0};
        btn_count     = '{default: '0};
        cur_setpoint  = RST_INIT_SETPOINT;
        mode_heat     = 1'b1;
        idle_flag     = 1'b1;
        avg_now       = int'(RST_START_AVERAGE);
        sec_sum       = 0;
        sec_count     = 0;

        passes_sent    = 0;
        windows_done   = 0;
        setpoint_steps = 0;
        settings_used  = 1;
        steady         = 1'b0;
        hold_req       = 1'b0;
        held           = '{default: 1'b0};
        sim_ms         = '0;
        temp_target    = 24;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table under the reset defaults
        for (int i = 0; i < N_OPENING; i++)
            offer_pass(OPENING_PASSES[i].stim, OPENING_PASSES[i].typed, OPENING_PASSES[i].want);
        sim_ms = 32'd5;

        // Defaults rewritten explicitly, with a different start average
        program_settings(16'd20, 8'd3, 7'd5, 7'd30, 4'd1, 7'd24, 8'sd48);
        pick_target();
        run_random(160);

        // Fastest buttons, widest limits, no band; neither side idles
        program_settings(16'd0, 8'd1, 7'd0, 7'd80, 4'd0, 7'd0, -8'sd40);
        steady = 1'b1;
        sim_ms = 32'hFFFF_FFFF - NOW_W'($urandom_range(0, 3000));
        pick_target();
        run_random(160);
        steady = 1'b0;

        // Slowest buttons, widest band, limits out of order
        program_settings(16'hFFFF, 8'd255, 7'd80, 7'd0, 4'd15, 7'd80, 8'sd80);
        pick_target();
        run_random(120);

        // Mid settings, with a long result-side hold-off and a full pause
        program_settings(16'd7, 8'd2, 7'd42, 7'd63, 4'd3, 7'd55, -8'sd33);
        sim_ms = 32'hFFFF_FFFF - NOW_W'($urandom_range(0, 3000));
        pick_target();
        run_random(60);
        hold_req = 1'b1;
        run_random(60);
        drain_status();
        run_random(80);

        // Random settings within the legal ranges
        program_settings(DELAY_W'($urandom_range(0, 60)), PRESS_W'($urandom_range(1, 4)),
                         SP_W'($urandom_range(0, 40)), SP_W'($urandom_range(40, 80)),
                         BAND_W'($urandom_range(0, 15)), SP_W'($urandom_range(0, 80)),
                         TEMP_W'($urandom_range(0, 120) - 40));
        pick_target();
        run_random(190);

        // Wait for the pipeline to empty, then allow stray transfers to show
        drain_status();
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("Covered %0d control passes over %0d register settings, %0d averaging windows",
                 passes_sent, settings_used, windows_done);
        $display("and %0d setpoint steps; %0d statuses checked, %0d mismatches",
                 setpoint_steps, status_seen, status_bad);
        if (status_bad == 0 && due_status.size() == 0) begin
            $display("PASS thermostat_hysteresis_controller_top");
        end else begin
            $display("FAIL thermostat_hysteresis_controller_top");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side: random stalls, plus the long hold-off on request
    // ------------------------------------------------------------------------
    initial begin
        m_ready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req) begin
                // hold off while the sender keeps offering, so the block backs up
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else begin
                m_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
            end
            @(posedge aclk);
        end
    end

    // ------------------------------------------------------------------------
    // Status checking
    // ------------------------------------------------------------------------
    task automatic note_mismatch(input string what);
        status_bad++;
        if (status_bad <= MAX_REPORTS)
            $display("[%0t] status mismatch: %s", $realtime, what);
    endtask

    always @(posedge aclk) begin
        status_t want;
        if (aresetn && m_valid && m_ready) begin
            status_seen++;
            if (due_status.size() == 0) begin
                note_mismatch("transfer with no status owed");
            end else begin
                want = due_status.pop_front();
                if (m_setpoint !== want.setpoint || m_average_temp !== want.average_temp ||
                    m_heating !== want.heating || m_stopped !== want.stopped ||
                    m_op_state !== want.op_state || m_heat_relay_n !== want.heat_relay_n ||
                    m_cool_relay_n !== want.cool_relay_n) begin
                    note_mismatch($sformatf(
                        "sp %0d/%0d avg %0d/%0d heat %b/%b stop %b/%b op %0d/%0d rly %b%b/%b%b",
                        m_setpoint, want.setpoint, m_average_temp, want.average_temp,
                        m_heating, want.heating, m_stopped, want.stopped,
                        m_op_state, want.op_state, m_heat_relay_n, m_cool_relay_n,
                        want.heat_relay_n, want.cool_relay_n));
                end
            end
        end
    end

    initial status_seen = 0;
    initial status_bad  = 0;

    // Guard against a hung handshake
    initial begin
        #3_000_000;
        $display("FAIL thermostat_hysteresis_controller_top");
        $finish;
    end

endmodule
